FILE: src/delta_list_task_timer_queue_macros.svh
// Assertion macros shared by the delta-list timer queue RTL.
`ifndef DELTA_LIST_TASK_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TASK_TIMER_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
`define DLTQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DLTQ_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DLTQ_ASSERT(label, clk, rst_n, prop, msg)
`define DLTQ_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

FILE: src/dltq_pkg.sv
// Types and codes for the delta-list task timer queue.
package dltq_pkg;

  localparam int unsigned MaxTasksDefault = 16;

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_DISPATCH = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NONE_DUE = 2'd2;

  localparam logic [7:0] PendMax = 8'hFF;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] delta;
    logic [31:0] period;
    logic [7:0]  pend;
  } entry_t;

endpackage

FILE: src/delta_list_task_timer_queue.sv
// Delta-list task timer queue: deadline-ordered task list with add, tick and dispatch.
//
// An add that finds room, and a dispatch that re-queues a periodic task, run an
// insertion pass between the execute and response steps; other commands skip it.
// The insertion pass rotates the whole list once through the head slot, one slot a
// cycle, past an adder and a comparator that track the running deadline and
// place the new entry. A new item is taken only when the block is idle; the
// finished result sits in an output register until its transfer.
`include "delta_list_task_timer_queue_macros.svh"

module delta_list_task_timer_queue
  import dltq_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MaxTasksDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  task_id_i,
  input  logic [31:0] start_delay_i,
  input  logic [31:0] repeat_period_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        due_valid_o,
  output logic [7:0]  due_task_id_o
);

  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam int unsigned IdxW = $clog2(MAX_TASKS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  entry_t            ent_q [MAX_TASKS];
  entry_t            ent_d [MAX_TASKS];
  logic [CntW-1:0]   count_q, count_d;
  logic [1:0]        cmd_q, cmd_d;
  entry_t            new_q, new_d;
  entry_t            hold_q, hold_d;
  logic [31:0]       before_q, before_d;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic              ins_q, ins_d;
  logic [1:0]        res_status_q, res_status_d;
  logic              res_due_q, res_due_d;
  logic [7:0]        res_id_q, res_id_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic              due_valid_q, due_valid_d;
  logic [7:0]        due_id_q, due_id_d;

  entry_t            head;
  entry_t            push;
  logic [32:0]       cum;
  logic [32:0]       rest;
  logic              scan_last;

  assign head      = ent_q[0];
  assign cum       = {1'b0, before_q} + {1'b0, head.delta};
  assign rest      = cum - {1'b0, new_q.delta};
  assign scan_last = (scan_q == IdxW'(MAX_TASKS - 1));

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign due_valid_o   = due_valid_q;
  assign due_task_id_o = due_id_q;

  always_comb begin
    state_d      = state_q;
    ent_d        = ent_q;
    count_d      = count_q;
    cmd_d        = cmd_q;
    new_d        = new_q;
    hold_d       = hold_q;
    before_d     = before_q;
    scan_d       = scan_q;
    ins_d        = ins_q;
    res_status_d = res_status_q;
    res_due_d    = res_due_q;
    res_id_d     = res_id_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    due_valid_d  = due_valid_q;
    due_id_d     = due_id_q;
    push         = hold_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = command_i;
          new_d.id     = task_id_i;
          new_d.delta  = start_delay_i;
          new_d.period = repeat_period_i;
          new_d.pend   = 8'd0;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d = ST_DONE;
        res_due_d    = 1'b0;
        res_id_d     = 8'd0;
        before_d     = 32'd0;
        scan_d       = '0;
        ins_d        = 1'b0;
        state_d      = S_RESP;
        case (cmd_q)
          CMD_ADD: begin
            if (count_q == CntW'(MAX_TASKS)) begin
              res_status_d = ST_FULL;
            end else begin
              state_d = S_SCAN;
            end
          end
          CMD_TICK: begin
            if (count_q != '0) begin
              if (head.delta == 32'd0) begin
                if (head.pend != PendMax) begin
                  ent_d[0].pend = head.pend + 8'd1;
                end
                if (head.period != 32'd0) begin
                  ent_d[0].delta = head.period;
                end
              end else begin
                ent_d[0].delta = head.delta - 32'd1;
              end
            end
          end
          CMD_DISPATCH: begin
            if (count_q != '0 && head.pend != 8'd0) begin
              res_due_d = 1'b1;
              res_id_d  = head.id;
              for (int k = 0; k < MAX_TASKS - 1; k++) begin
                ent_d[k] = ent_q[k+1];
              end
              ent_d[MAX_TASKS-1] = '0;
              count_d = count_q - CntW'(1);
              if (head.period != 32'd0) begin
                new_d      = head;
                new_d.pend = head.pend - 8'd1;
                state_d    = S_SCAN;
              end
            end else begin
              res_status_d = ST_NONE_DUE;
            end
          end
          default: begin
            res_status_d = ST_DONE;
          end
        endcase
      end
      S_SCAN: begin
        // One slot leaves the head and is written back at the tail each cycle.
        // The entry displaced by the insertion rides in the hold register.
        hold_d = head;
        if (!ins_q) begin
          if (CntW'(scan_q) < count_q) begin
            if ({1'b0, new_q.delta} <= cum) begin
              push        = new_q;
              push.delta  = new_q.delta - before_q;
              hold_d.delta = rest[31:0];
              ins_d       = 1'b1;
            end else begin
              push     = head;
              before_d = cum[31:0];
            end
          end else begin
            push       = new_q;
            push.delta = new_q.delta - before_q;
            ins_d      = 1'b1;
          end
        end
        for (int k = 0; k < MAX_TASKS - 1; k++) begin
          ent_d[k] = ent_q[k+1];
        end
        ent_d[MAX_TASKS-1] = push;
        scan_d = scan_q + IdxW'(1);
        if (scan_last) begin
          count_d = count_q + CntW'(1);
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          due_valid_d = res_due_q;
          due_id_d    = res_id_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ins_q       <= 1'b0;
      scan_q      <= '0;
      for (int k = 0; k < MAX_TASKS; k++) begin
        ent_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      ins_q       <= ins_d;
      scan_q      <= scan_d;
      ent_q       <= ent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    new_q        <= new_d;
    hold_q       <= hold_d;
    before_q     <= before_d;
    res_status_q <= res_status_d;
    res_due_q    <= res_due_d;
    res_id_q     <= res_id_d;
    status_q     <= status_d;
    due_valid_q  <= due_valid_d;
    due_id_q     <= due_id_d;
  end

  `DLTQ_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CntW'(MAX_TASKS), "entry count exceeds capacity")
  `DLTQ_ASSERT(a_scan_places_entry, clk_i, rst_ni, (state_q == S_SCAN && scan_last) |-> (ins_q || ins_d), "insertion pass ended without placing the entry")
  `DLTQ_ASSERT(a_result_from_resp, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_RESP), "result raised outside the response step")
  `DLTQ_ASSERT(a_count_moves_in_work, clk_i, rst_ni, (count_q != $past(count_q)) |-> ($past(state_q == S_EXEC) || $past(state_q == S_SCAN)), "entry count changed while idle")

endmodule
